// File: hdl/cps_pkg.sv
// Shared types, constants and codes for the cuff pressure sequencer.
package cps_pkg;

	localparam int SAMPLE_BITS_DEF = 12;
	localparam int CLOSE_WAIT_DEF  = 80;
	localparam int PUMP_WAIT_DEF   = 300;

	localparam int DELAY_W   = 9;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 32;
	localparam int PRESS_W   = 32;
	localparam int PHASE_W   = 3;
	// products and sums of the pressure polynomial, sized for 16-bit samples
	localparam int PROD_W    = 52;
	localparam int FRAC_BITS = 16;

	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE      = 3'd0,
		PH_CLOSE     = 3'd1,
		PH_PUMP      = 3'd2,
		PH_INFLATE   = 3'd3,
		PH_SYSTOLIC  = 3'd4,
		PH_DIASTOLIC = 3'd5,
		PH_VENT      = 3'd6
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OFFSET = 3'd0,
		CFG_LINEAR = 3'd1,
		CFG_SQUARE = 3'd2,
		CFG_LIMIT  = 3'd3,
		CFG_ABORT  = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_SUM,
		ST_SAT,
		ST_COMMIT
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic mul_a;
		logic mul_b;
		logic sum;
		logic sat;
		logic commit;
	} dp_cmd_t;

endpackage

// File: hdl/cps_if.sv
// Valid/ready channel interfaces for sample words and result words.
interface cps_sample_if #(
	parameter int SAMPLE_BITS = cps_pkg::SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic                   mode;
	logic [SAMPLE_BITS-1:0] adc_sample;
	logic                   tones_present;

	modport source (output valid, mode, adc_sample, tones_present, input ready);
	modport sink   (input valid, mode, adc_sample, tones_present, output ready);
endinterface

interface cps_result_if;
	logic                          valid;
	logic                          ready;
	logic                          valve_closed;
	logic                          compressor_on;
	logic signed [cps_pkg::PRESS_W-1:0] tube_pressure;
	logic signed [cps_pkg::PRESS_W-1:0] systolic;
	logic signed [cps_pkg::PRESS_W-1:0] diastolic;
	logic [cps_pkg::PHASE_W-1:0]   phase;

	modport source (output valid, valve_closed, compressor_on, tube_pressure, systolic,
		diastolic, phase, input ready);
	modport sink   (input valid, valve_closed, compressor_on, tube_pressure, systolic,
		diastolic, phase, output ready);
endinterface

// File: hdl/cps_ctrl.sv
// Cycle sequencer: steps one word through multiply, sum, saturate and commit.
module cps_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output cps_pkg::dp_cmd_t cmd
);
	import cps_pkg::*;

	ctrl_state_t state_q, state_nxt;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_MUL_A;
				end
			end
			ST_MUL_A: begin
				cmd.mul_a = 1'b1;
				state_nxt = ST_MUL_B;
			end
			ST_MUL_B: begin
				cmd.mul_b = 1'b1;
				state_nxt = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum   = 1'b1;
				state_nxt = ST_SAT;
			end
			ST_SAT: begin
				cmd.sat   = 1'b1;
				state_nxt = ST_COMMIT;
			end
			ST_COMMIT: begin
				// result slot must be free before the state moves on
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// File: hdl/cps_datapath.sv
// Pressure polynomial, configuration registers and measurement phase state.
module cps_datapath #(
	parameter int SAMPLE_BITS      = cps_pkg::SAMPLE_BITS_DEF,
	parameter int CLOSE_WAIT_TICKS = cps_pkg::CLOSE_WAIT_DEF,
	parameter int PUMP_WAIT_TICKS  = cps_pkg::PUMP_WAIT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cps_pkg::dp_cmd_t                   cmd,
	input  logic                               cfg_we,
	input  logic [cps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cps_pkg::CFG_W-1:0]          cfg_data,
	input  logic                               mode,
	input  logic [SAMPLE_BITS-1:0]             adc_sample,
	input  logic                               tones_present,
	output logic                               valve_closed,
	output logic                               compressor_on,
	output logic signed [cps_pkg::PRESS_W-1:0] tube_pressure,
	output logic signed [cps_pkg::PRESS_W-1:0] systolic,
	output logic signed [cps_pkg::PRESS_W-1:0] diastolic,
	output logic [cps_pkg::PHASE_W-1:0]        phase
);
	import cps_pkg::*;

	localparam logic [DELAY_W-1:0] CLOSE_WAIT = DELAY_W'(CLOSE_WAIT_TICKS);
	localparam logic [DELAY_W-1:0] PUMP_WAIT  = DELAY_W'(PUMP_WAIT_TICKS);

	// configuration
	logic signed [PRESS_W-1:0] offset_q, linear_q, square_q, limit_q, abort_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			linear_q <= PRESS_W'(65536);
			square_q <= '0;
			limit_q  <= '0;
			abort_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_OFFSET: offset_q <= cfg_data;
				CFG_LINEAR: linear_q <= cfg_data;
				CFG_SQUARE: square_q <= cfg_data;
				CFG_LIMIT:  limit_q  <= cfg_data;
				CFG_ABORT:  abort_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// captured word
	logic                   mode_q, tones_q;
	logic [SAMPLE_BITS-1:0] sample_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= mode;
			sample_q <= adc_sample;
			tones_q  <= tones_present;
		end
	end

	// polynomial: offset + floor((lin*s + sq*qlo) / 2^16) + sq*qhi, q = s*s
	logic [31:0]              s32, sq_s1;
	logic signed [PROD_W-1:0] s_ext, lin_ext, sqr_ext, off_ext, qlo_ext, qhi_ext;
	logic signed [PROD_W-1:0] lin_s1, sqlo_s2, sqhi_s2, frac_s3, psum;
	logic signed [PRESS_W-1:0] pres_s4, pres_sat;

	assign s32     = 32'(sample_q);
	assign s_ext   = PROD_W'(sample_q);
	assign lin_ext = PROD_W'(linear_q);
	assign sqr_ext = PROD_W'(square_q);
	assign off_ext = PROD_W'(offset_q);
	assign qlo_ext = PROD_W'(sq_s1[15:0]);
	assign qhi_ext = PROD_W'(sq_s1[31:16]);
	assign psum    = off_ext + (frac_s3 >>> FRAC_BITS) + sqhi_s2;

	always_comb begin
		if (psum[PROD_W-1:PRESS_W-1] == '0 || psum[PROD_W-1:PRESS_W-1] == '1)
			pres_sat = psum[PRESS_W-1:0];
		else if (psum[PROD_W-1])
			pres_sat = {1'b1, {(PRESS_W-1){1'b0}}};
		else
			pres_sat = {1'b0, {(PRESS_W-1){1'b1}}};
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_a) begin
			sq_s1  <= s32 * s32;
			lin_s1 <= lin_ext * s_ext;
		end
		if (cmd.mul_b) begin
			sqlo_s2 <= sqr_ext * qlo_ext;
			sqhi_s2 <= sqr_ext * qhi_ext;
		end
		if (cmd.sum)
			frac_s3 <= lin_s1 + sqlo_s2;
		if (cmd.sat)
			pres_s4 <= pres_sat;
	end

	// measurement state
	phase_t                    phase_q, phase_nxt, phase_cur;
	logic [DELAY_W-1:0]        delay_q, delay_nxt;
	logic signed [PRESS_W-1:0] press_q, press_nxt, sys_q, sys_nxt, dia_q, dia_nxt;
	logic                      valve_q, valve_nxt, pump_q, pump_nxt;
	logic                      run_step;

	assign run_step  = mode_q || (delay_q == '0);
	assign phase_cur = mode_q ? PH_CLOSE : phase_q;

	always_comb begin
		phase_nxt = phase_q;
		delay_nxt = delay_q;
		press_nxt = press_q;
		sys_nxt   = sys_q;
		dia_nxt   = dia_q;
		valve_nxt = valve_q;
		pump_nxt  = pump_q;
		if (run_step) begin
			press_nxt = pres_s4;
			phase_nxt = phase_cur;
			unique case (phase_cur)
				PH_IDLE: ;
				PH_CLOSE: begin
					valve_nxt = 1'b1;
					delay_nxt = CLOSE_WAIT;
					phase_nxt = PH_PUMP;
				end
				PH_PUMP: begin
					pump_nxt  = 1'b1;
					delay_nxt = PUMP_WAIT;
					phase_nxt = PH_INFLATE;
				end
				PH_INFLATE: begin
					if (pres_s4 > limit_q) begin
						pump_nxt  = 1'b0;
						phase_nxt = PH_SYSTOLIC;
					end else begin
						delay_nxt = PUMP_WAIT;
					end
				end
				PH_SYSTOLIC: begin
					if (tones_q) begin
						sys_nxt   = pres_s4;
						phase_nxt = PH_DIASTOLIC;
					end
					if (pres_s4 < abort_q)
						phase_nxt = PH_VENT;
				end
				PH_DIASTOLIC: begin
					if (!tones_q) begin
						dia_nxt   = pres_s4;
						phase_nxt = PH_VENT;
					end
					if (pres_s4 < abort_q)
						phase_nxt = PH_VENT;
				end
				PH_VENT: begin
					valve_nxt = 1'b0;
					phase_nxt = PH_IDLE;
				end
				default: phase_nxt = PH_IDLE;
			endcase
		end else begin
			delay_nxt = delay_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			delay_q <= '0;
			press_q <= '0;
			sys_q   <= '0;
			dia_q   <= '0;
			valve_q <= 1'b0;
			pump_q  <= 1'b0;
		end else if (cmd.commit) begin
			phase_q <= phase_nxt;
			delay_q <= delay_nxt;
			press_q <= press_nxt;
			sys_q   <= sys_nxt;
			dia_q   <= dia_nxt;
			valve_q <= valve_nxt;
			pump_q  <= pump_nxt;
		end
	end

	assign valve_closed  = valve_q;
	assign compressor_on = pump_q;
	assign tube_pressure = press_q;
	assign systolic      = sys_q;
	assign diastolic     = dia_q;
	assign phase         = phase_q;

endmodule

// File: hdl/cuff_pressure_measure_sequencer.sv
// Top level of the blood-pressure cuff measurement sequencer.
// The result word is registered at the commit step and held until it is taken.
// One word at a time: the two multiply stages, the sum and the saturation stage
//   run in sequence before the phase state commits; then a new word is accepted.
// A commit waits while the previous result word is still held on the output.
// Reset (arst_n low): idle phase, valve open, compressor off, all values zero but the linear coefficient (65536).
module cuff_pressure_measure_sequencer #(
	parameter int SAMPLE_BITS      = cps_pkg::SAMPLE_BITS_DEF,
	parameter int CLOSE_WAIT_TICKS = cps_pkg::CLOSE_WAIT_DEF,
	parameter int PUMP_WAIT_TICKS  = cps_pkg::PUMP_WAIT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cps_pkg::CFG_W-1:0]     cfg_data,
	cps_sample_if.sink                    sample_ch,
	cps_result_if.source                  result_ch
);
	import cps_pkg::*;

	dp_cmd_t cmd;

	cps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample_ch.valid),
		.in_ready  (sample_ch.ready),
		.out_valid (result_ch.valid),
		.out_ready (result_ch.ready),
		.cmd       (cmd)
	);

	cps_datapath #(
		.SAMPLE_BITS      (SAMPLE_BITS),
		.CLOSE_WAIT_TICKS (CLOSE_WAIT_TICKS),
		.PUMP_WAIT_TICKS  (PUMP_WAIT_TICKS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mode          (sample_ch.mode),
		.adc_sample    (sample_ch.adc_sample),
		.tones_present (sample_ch.tones_present),
		.valve_closed  (result_ch.valve_closed),
		.compressor_on (result_ch.compressor_on),
		.tube_pressure (result_ch.tube_pressure),
		.systolic      (result_ch.systolic),
		.diastolic     (result_ch.diastolic),
		.phase         (result_ch.phase)
	);

endmodule

// File: hdl/cps_checker.sv
// Port-level checks for the cuff pressure sequencer, bound to the top level.
module cps_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic                               valve_closed,
	input logic                               compressor_on,
	input logic signed [cps_pkg::PRESS_W-1:0] tube_pressure,
	input logic signed [cps_pkg::PRESS_W-1:0] systolic,
	input logic [cps_pkg::PHASE_W-1:0]        phase
);
	import cps_pkg::*;

	// words accepted but not yet delivered
	logic [1:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else
			pend_q <= pend_q + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tube_pressure))
		else $error("result word changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result word without an accepted input word");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many words in flight");

	a_idle_safe: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase == PH_IDLE |-> !valve_closed && !compressor_on)
		else $error("idle with valve closed or compressor running");

	a_sys_capture: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(systolic) |-> phase == PH_DIASTOLIC || phase == PH_VENT)
		else $error("systolic changed outside its capture step");

endmodule

bind cuff_pressure_measure_sequencer cps_checker u_cps_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (sample_ch.valid),
	.in_ready      (sample_ch.ready),
	.out_valid     (result_ch.valid),
	.out_ready     (result_ch.ready),
	.valve_closed  (result_ch.valve_closed),
	.compressor_on (result_ch.compressor_on),
	.tube_pressure (result_ch.tube_pressure),
	.systolic      (result_ch.systolic),
	.phase         (result_ch.phase)
);

// File: test/cuff_pressure_measure_sequencer_tb.sv
// Self-checking testbench of the cuff pressure sequencer against a behavioral predictor.
module cuff_pressure_measure_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cps_pkg::*;

	localparam int SAMPLE_W = SAMPLE_BITS_DEF;
	localparam bit MODE_TICK = 1'b0;
	localparam bit MODE_START = 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	localparam int SETTLE_CYCLES = 8;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_ITEMS = 850;
	localparam longint P_MAX = 2147483647;
	localparam longint P_MIN = -P_MAX - 1;

	typedef struct {
		bit                        valve;
		bit                        pump;
		logic signed [PRESS_W-1:0] press;
		logic signed [PRESS_W-1:0] sys;
		logic signed [PRESS_W-1:0] dia;
		phase_t                    phase;
	} cuff_word_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	cps_sample_if sample_ch();
	cps_result_if result_ch();

	cuff_pressure_measure_sequencer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample_ch (sample_ch),
		.result_ch (result_ch)
	);

	// predictor state
	logic signed [PRESS_W-1:0] cfg_offset, cfg_linear, cfg_square, cfg_limit, cfg_abort;
	phase_t                    ph;
	bit [DELAY_W-1:0]          delay_cnt;
	logic signed [PRESS_W-1:0] press_q, sys_q, dia_q;
	bit                        valve_q, pump_q;

	cuff_word_t pending_words[$];
	int mismatches;
	int sent_count;
	int idle_cycles;
	int gap_max;
	int stall_max;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic void cuff_reset();
		cfg_offset = 0;
		cfg_linear = 65536;
		cfg_square = 0;
		cfg_limit  = 0;
		cfg_abort  = 0;
		ph         = PH_IDLE;
		delay_cnt  = 0;
		press_q    = 0;
		sys_q      = 0;
		dia_q      = 0;
		valve_q    = 1'b0;
		pump_q     = 1'b0;
	endfunction

	// offset + floor((linear*s + square*s*s) / 2^16), saturated
	function automatic logic signed [PRESS_W-1:0] cuff_pressure(logic [SAMPLE_W-1:0] raw);
		longint s, acc, p;
		s = longint'(raw);
		acc = longint'(cfg_linear) * s + longint'(cfg_square) * s * s;
		p = longint'(cfg_offset) + (acc >>> FRAC_BITS);
		if (p > P_MAX)
			p = P_MAX;
		if (p < P_MIN)
			p = P_MIN;
		return p[PRESS_W-1:0];
	endfunction

	function automatic void cuff_phase_step(logic [SAMPLE_W-1:0] raw, bit tones);
		press_q = cuff_pressure(raw);
		case (ph)
			PH_CLOSE: begin
				valve_q = 1'b1;
				delay_cnt = DELAY_W'(CLOSE_WAIT_DEF);
				ph = PH_PUMP;
			end
			PH_PUMP: begin
				pump_q = 1'b1;
				delay_cnt = DELAY_W'(PUMP_WAIT_DEF);
				ph = PH_INFLATE;
			end
			PH_INFLATE: begin
				if (press_q > cfg_limit) begin
					pump_q = 1'b0;
					ph = PH_SYSTOLIC;
				end else begin
					delay_cnt = DELAY_W'(PUMP_WAIT_DEF);
				end
			end
			PH_SYSTOLIC: begin
				if (tones) begin
					sys_q = press_q;
					ph = PH_DIASTOLIC;
				end
				if (press_q < cfg_abort)
					ph = PH_VENT;
			end
			PH_DIASTOLIC: begin
				if (!tones) begin
					dia_q = press_q;
					ph = PH_VENT;
				end
				if (press_q < cfg_abort)
					ph = PH_VENT;
			end
			PH_VENT: begin
				valve_q = 1'b0;
				ph = PH_IDLE;
			end
			default: begin
				ph = PH_IDLE;
			end
		endcase
	endfunction

	function automatic void cuff_predict(bit mode, logic [SAMPLE_W-1:0] raw, bit tones);
		cuff_word_t w;
		if (mode == MODE_START) begin
			ph = PH_CLOSE;
			cuff_phase_step(raw, tones);
		end else if (delay_cnt == 0) begin
			cuff_phase_step(raw, tones);
		end else begin
			delay_cnt = delay_cnt - 1'b1;
		end
		w.valve = valve_q;
		w.pump  = pump_q;
		w.press = press_q;
		w.sys   = sys_q;
		w.dia   = dia_q;
		w.phase = ph;
		pending_words.push_back(w);
	endfunction

	function automatic void check_field(string name, logic signed [PRESS_W-1:0] want,
		logic signed [PRESS_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		cuff_word_t exp_w;
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (pending_words.size() == 0) begin
				$display("%0t: result word with none expected", $time);
				mismatches++;
			end else begin
				exp_w = pending_words.pop_front();
				check_field("valve_closed", PRESS_W'(exp_w.valve),
					PRESS_W'(result_ch.valve_closed));
				check_field("compressor_on", PRESS_W'(exp_w.pump),
					PRESS_W'(result_ch.compressor_on));
				check_field("tube_pressure", exp_w.press, result_ch.tube_pressure);
				check_field("systolic", exp_w.sys, result_ch.systolic);
				check_field("diastolic", exp_w.dia, result_ch.diastolic);
				check_field("phase", PRESS_W'(exp_w.phase), PRESS_W'(result_ch.phase));
			end
		end
	end

	always @(posedge clk) begin
		if ((sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1) ||
			(result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, idle_cycles);
			$display("cuff_pressure_measure_sequencer: mismatch");
			$finish;
		end
	end

	initial begin
		int stall;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = $urandom_range(stall_max, 0);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (result_ch.valid !== 1'b1);
		end
	end

	task automatic send_word(bit mode, logic [SAMPLE_W-1:0] raw, bit tones);
		int gap;
		gap = $urandom_range(gap_max, 0);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid         <= 1'b1;
		sample_ch.mode          <= mode;
		sample_ch.adc_sample    <= raw;
		sample_ch.tones_present <= tones;
		do
			@(posedge clk);
		while (sample_ch.ready !== 1'b1);
		cuff_predict(mode, raw, tones);
		sent_count++;
	endtask

	task automatic settle();
		sample_ch.valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			CFG_OFFSET: cfg_offset = data;
			CFG_LINEAR: cfg_linear = data;
			CFG_SQUARE: cfg_square = data;
			CFG_LIMIT:  cfg_limit  = data;
			CFG_ABORT:  cfg_abort  = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_config(logic [CFG_W-1:0] offset, logic [CFG_W-1:0] linear,
		logic [CFG_W-1:0] square, logic [CFG_W-1:0] limit, logic [CFG_W-1:0] abort_min);
		settle();
		write_reg(CFG_OFFSET, offset);
		write_reg(CFG_LINEAR, linear);
		write_reg(CFG_SQUARE, square);
		write_reg(CFG_LIMIT, limit);
		write_reg(CFG_ABORT, abort_min);
		cfg_we <= 1'b0;
	endtask

	// reset coefficients, idle ticks only convert the sample
	task automatic test_idle_ticks();
		gap_max = 0;
		stall_max = 0;
		send_word(MODE_TICK, 12'h000, 1'b0);
		send_word(MODE_TICK, 12'hFFF, 1'b1);
		send_word(MODE_TICK, 12'hAAA, 1'b0);
		send_word(MODE_TICK, 12'h555, 1'b1);
	endtask

	task automatic test_conversion_extremes();
		gap_max = 9;
		stall_max = 9;
		load_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_word(MODE_TICK, 12'hFFF, 1'b1);
		load_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_word(MODE_TICK, 12'hFFF, 1'b0);
		send_word(MODE_TICK, 12'h000, 1'b1);
		// negative fraction rounds toward minus infinity
		load_config(32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
		send_word(MODE_TICK, 12'h001, 1'b0);
		load_config(32'd100, 32'd65536, 32'hFFFF_0000, 32'd0, 32'd0);
		send_word(MODE_TICK, 12'h800, 1'b1);
		// unused register index has no effect
		settle();
		write_reg(CFG_UNUSED, $urandom);
		cfg_we <= 1'b0;
		send_word(MODE_TICK, 12'h123, 1'b0);
	endtask

	task automatic test_restart();
		load_config(32'd0, 32'd65536, 32'd0, 32'd1000, 32'd100);
		send_word(MODE_START, 12'h400, 1'b1);
		send_word(MODE_TICK, 12'hFFF, 1'b0);
		send_word(MODE_TICK, 12'h000, 1'b1);
		send_word(MODE_TICK, 12'h7FF, 1'b0);
		send_word(MODE_START, 12'h800, 1'b0);
		send_word(MODE_TICK, 12'h001, 1'b1);
	endtask

	// start, wait out close and pump delays, inflate, then capture and vent
	task automatic full_run();
		int tail;
		bit deep;
		logic [SAMPLE_W-1:0] raw;
		gap_max = ($urandom_range(3, 0) == 0) ? 0 : 9;
		stall_max = ($urandom_range(3, 0) == 0) ? 0 : 9;
		load_config(int'($urandom_range(400, 0)) - 200, $urandom_range(131072, 32768),
			$urandom_range(16, 0), $urandom_range(1500, 300), $urandom_range(600, 0));
		send_word(MODE_START, SAMPLE_W'($urandom_range(4095, 0)), 1'($urandom_range(1, 0)));
		tail = $urandom_range(60, 20);
		deep = 1'b0;
		while (!deep || tail > 0) begin
			if (ph == PH_INFLATE && delay_cnt == 0)
				raw = SAMPLE_W'($urandom_range(4095, 3500));
			else if (deep && $urandom_range(4, 0) == 0)
				raw = SAMPLE_W'($urandom_range(300, 0));
			else
				raw = SAMPLE_W'($urandom_range(4095, 0));
			send_word(MODE_TICK, raw, 1'($urandom_range(1, 0)));
			if (deep)
				tail--;
			else if (ph >= PH_SYSTOLIC) begin
				deep = 1'b1;
				settle();
			end
		end
	endtask

	// arbitrary coefficients, stray starts and restarts
	task automatic broken_run();
		int n;
		gap_max = 9;
		stall_max = 9;
		load_config($urandom, $urandom, $urandom, $urandom, $urandom);
		n = $urandom_range(40, 10);
		repeat (n)
			send_word(($urandom_range(7, 0) == 0) ? MODE_START : MODE_TICK,
				SAMPLE_W'($urandom_range(4095, 0)), 1'($urandom_range(1, 0)));
	endtask

	task automatic test_random_runs();
		int base;
		int run;
		base = sent_count;
		run = 0;
		while (sent_count - base < RANDOM_ITEMS) begin
			if (run % 2 == 0)
				full_run();
			else
				broken_run();
			run++;
		end
	endtask

	initial begin
		arst_n                  <= 1'b0;
		cfg_we                  <= 1'b0;
		cfg_index               <= CFG_OFFSET;
		cfg_data                <= '0;
		sample_ch.valid         <= 1'b0;
		sample_ch.mode          <= MODE_TICK;
		sample_ch.adc_sample    <= '0;
		sample_ch.tones_present <= 1'b0;
		gap_max = 0;
		stall_max = 0;
		cuff_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_ticks();
		test_conversion_extremes();
		test_restart();
		test_random_runs();
		settle();
		if (mismatches == 0 && pending_words.size() == 0)
			$display("cuff_pressure_measure_sequencer: match");
		else
			$display("cuff_pressure_measure_sequencer: mismatch");
		$finish;
	end

endmodule
